@@ hw/rtl/mhpq_pkg.sv @@
// Package for the min-heap priority queue: transfer structs, command and
// status codes, and the controller state type.
// Depends on nothing; the top level, the checker and the testbench use it.
`default_nettype none

package mhpq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic               command;
    logic signed [31:0] key_value;
  } request_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [5:0]         occupancy;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_POP_LOAD,
    ST_DOWN,
    ST_PLACE
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/mhpq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/min_heap_priority_queue_unit.sv @@
// Top level of the min-heap priority queue: controller and two mirrored heap RAMs.
// Depends on mhpq_pkg and mhpq_ram.
//
// Usage: an item is transferred at a rising edge with start high and busy low.
// request.command selects insert or pop; request.key_value is the key to insert.
// Each item gives exactly one result, shown for one cycle with done high; the
// receiver cannot stall it. The result reports the popped minimum, a status
// (ok, insert rejected because full, pop rejected because empty) and the
// number of keys held after the item.
// The heap lives in two RAMs written identically, so that both children of a
// slot are read together. The moving key is kept in a register and only
// written once its final slot is known.
// A rejected item, or an insert into an empty heap, gives its result in the
// cycle after the transfer. Other inserts climb in ST_UP, ending in ST_PLACE
// if they reach the root; a pop loads the root and last key in ST_POP_LOAD
// and, if more than one key is left, descends in ST_DOWN, ending in ST_PLACE
// at a leaf. Each level takes one RAM read, one compare and one write.
// busy is high while an item is in work; done of one item can coincide with
// the transfer of the next. Reset empties the heap; the RAM contents need no
// clearing.
`default_nettype none

module min_heap_priority_queue_unit #(
  parameter int CAPACITY = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire mhpq_pkg::request_t request,
  output logic                   busy,
  output logic                   done,
  output mhpq_pkg::result_t      result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);

  mhpq_pkg::state_t   state;
  mhpq_pkg::state_t   state_next;
  logic [PW-1:0]      count;
  logic [PW-1:0]      count_next;
  logic [PW-1:0]      pos;
  logic [PW-1:0]      pos_next;
  logic signed [31:0] key;
  logic signed [31:0] key_next;
  logic signed [31:0] popped;
  logic signed [31:0] popped_next;
  logic               done_next;
  mhpq_pkg::result_t  result_next;
  logic [1:0]         status_next;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;
  logic [AW-1:0]      ra_addr;
  logic [AW-1:0]      rb_addr;
  logic [31:0]        ra_data;
  logic [31:0]        rb_data;

  logic               accept;
  logic               full;
  logic               empty;
  logic [PW-1:0]      parent_slot;
  logic [PW-1:0]      insert_slot;
  logic [PW:0]        n_ext;
  logic [PW:0]        left_slot;
  logic [PW:0]        right_slot;
  logic               has_right;
  logic               pick_right;
  logic [PW:0]        child_slot;
  logic signed [31:0] child_val;
  logic               child_less;
  logic               key_less_parent;
  logic [PW+1:0]      grand_left;
  logic               child_is_leaf;

  mhpq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ra_addr),
    .rdata (ra_data)
  );

  mhpq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rb_addr),
    .rdata (rb_data)
  );

  assign busy   = (state != mhpq_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count == PW'(CAPACITY));
  assign empty  = (count == '0);

  assign insert_slot     = count + PW'(1);
  assign parent_slot     = pos >> 1;
  assign n_ext           = (PW + 1)'(count);
  assign left_slot       = {pos, 1'b0};
  assign right_slot      = left_slot + (PW + 1)'(1);
  assign has_right       = (right_slot <= n_ext);
  assign pick_right      = has_right && ($signed(rb_data) < $signed(ra_data));
  assign child_slot      = pick_right ? right_slot : left_slot;
  assign child_val       = pick_right ? $signed(rb_data) : $signed(ra_data);
  assign child_less      = (child_val < key);
  assign key_less_parent = (key < $signed(ra_data));
  assign grand_left      = {child_slot, 1'b0};
  assign child_is_leaf   = (grand_left > (PW + 2)'(count));

  always_comb begin
    state_next = state;
    unique case (state)
      mhpq_pkg::ST_IDLE: begin
        if (accept) begin
          if (request.command == mhpq_pkg::CMD_INSERT) begin
            if (!full && !empty) begin
              state_next = mhpq_pkg::ST_UP;
            end
          end else if (!empty) begin
            state_next = mhpq_pkg::ST_POP_LOAD;
          end
        end
      end
      mhpq_pkg::ST_UP: begin
        if (!key_less_parent) begin
          state_next = mhpq_pkg::ST_IDLE;
        end else if (parent_slot == PW'(1)) begin
          state_next = mhpq_pkg::ST_PLACE;
        end
      end
      mhpq_pkg::ST_POP_LOAD: begin
        if (count > PW'(1)) begin
          state_next = mhpq_pkg::ST_DOWN;
        end else begin
          state_next = mhpq_pkg::ST_IDLE;
        end
      end
      mhpq_pkg::ST_DOWN: begin
        if (!child_less) begin
          state_next = mhpq_pkg::ST_IDLE;
        end else if (child_is_leaf) begin
          state_next = mhpq_pkg::ST_PLACE;
        end
      end
      mhpq_pkg::ST_PLACE: begin
        state_next = mhpq_pkg::ST_IDLE;
      end
      default: begin
        state_next = mhpq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_next  = count;
    pos_next    = pos;
    key_next    = key;
    popped_next = popped;
    done_next   = 1'b0;
    status_next = mhpq_pkg::STATUS_OK;
    we          = 1'b0;
    waddr       = AW'(pos - PW'(1));
    wdata       = key;
    ra_addr     = AW'((parent_slot >> 1) - PW'(1));
    rb_addr     = AW'(grand_left);
    unique case (state)
      mhpq_pkg::ST_IDLE: begin
        if (accept) begin
          popped_next = '0;
          if (request.command == mhpq_pkg::CMD_INSERT) begin
            key_next = request.key_value;
            ra_addr  = AW'((insert_slot >> 1) - PW'(1));
            if (full) begin
              done_next   = 1'b1;
              status_next = mhpq_pkg::STATUS_FULL;
            end else begin
              count_next = insert_slot;
              pos_next   = insert_slot;
              if (empty) begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = request.key_value;
                done_next = 1'b1;
              end
            end
          end else begin
            ra_addr = '0;
            rb_addr = AW'(count - PW'(1));
            if (empty) begin
              done_next   = 1'b1;
              status_next = mhpq_pkg::STATUS_EMPTY;
            end else begin
              count_next = count - PW'(1);
            end
          end
        end
      end
      mhpq_pkg::ST_UP: begin
        if (key_less_parent) begin
          we       = 1'b1;
          wdata    = ra_data;
          pos_next = parent_slot;
        end else begin
          we        = 1'b1;
          done_next = 1'b1;
        end
      end
      mhpq_pkg::ST_POP_LOAD: begin
        popped_next = $signed(ra_data);
        key_next    = $signed(rb_data);
        pos_next    = PW'(1);
        ra_addr     = AW'(1);
        rb_addr     = AW'(2);
        if (count == PW'(1)) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = rb_data;
          done_next = 1'b1;
        end else if (count == '0) begin
          done_next = 1'b1;
        end
      end
      mhpq_pkg::ST_DOWN: begin
        ra_addr = AW'(grand_left - (PW + 2)'(1));
        we      = 1'b1;
        if (child_less) begin
          wdata    = child_val;
          pos_next = PW'(child_slot);
        end else begin
          done_next = 1'b1;
        end
      end
      mhpq_pkg::ST_PLACE: begin
        we        = 1'b1;
        done_next = 1'b1;
      end
      default: begin
      end
    endcase
    result_next.popped_value = popped_next;
    result_next.status       = status_next;
    result_next.occupancy    = 6'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    pos    <= pos_next;
    key    <= key_next;
    popped <= popped_next;
    if (done_next) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mhpq_checker.sv @@
// Port-level checker for the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and min_heap_priority_queue_unit.
`default_nettype none

module mhpq_checker #(
  parameter int CAPACITY = 32
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire mhpq_pkg::request_t request,
  input wire logic              busy,
  input wire logic              done,
  input wire mhpq_pkg::result_t result
);

  // A result always ends the work on an item, so the block is free again.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // Work only starts from a transfer.
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

  // A rejected item never returns a key.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != mhpq_pkg::STATUS_OK) |-> (result.popped_value == '0))
    else $error("rejected item returned a key");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == mhpq_pkg::STATUS_EMPTY) |-> (result.occupancy == '0))
    else $error("empty rejection with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == mhpq_pkg::STATUS_FULL) |-> (result.occupancy == 6'(CAPACITY)))
    else $error("full rejection with wrong occupancy");

endmodule

bind min_heap_priority_queue_unit mhpq_checker #(.CAPACITY(CAPACITY)) u_mhpq_checker (.*);

`default_nettype wire

@@ dv/tb_min_heap_priority_queue_unit.sv @@
// Self-checking testbench for min_heap_priority_queue_unit: directed and random
// insert/pop traffic, checked against a behavioral heap kept in the testbench.
// Depends on mhpq_pkg and the RTL of min_heap_priority_queue_unit.
`timescale 1ns / 1ps

module tb_min_heap_priority_queue_unit;

  localparam int HEAP_DEPTH    = 32;
  localparam int SETTLE_CYCLES = 20;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  mhpq_pkg::request_t request = '0;
  logic               busy;
  logic               done;
  mhpq_pkg::result_t  result;

  mhpq_pkg::result_t  pending_results[$];
  logic signed [31:0] heap_keys[1:HEAP_DEPTH];
  int unsigned        heap_size    = 0;
  int                 error_count  = 0;
  bit                 gaps_enabled = 1'b1;

  min_heap_priority_queue_unit #(
    .CAPACITY(HEAP_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  function automatic mhpq_pkg::result_t heap_apply(input mhpq_pkg::request_t req);
    mhpq_pkg::result_t  res;
    int unsigned        pos;
    int unsigned        child;
    logic signed [31:0] held;
    res = '0;
    if (req.command == mhpq_pkg::CMD_INSERT) begin
      if (heap_size >= HEAP_DEPTH) begin
        res.status = mhpq_pkg::STATUS_FULL;
      end else begin
        heap_size++;
        heap_keys[heap_size] = req.key_value;
        pos = heap_size;
        while (pos > 1 && heap_keys[pos] < heap_keys[pos / 2]) begin
          held                 = heap_keys[pos];
          heap_keys[pos]       = heap_keys[pos / 2];
          heap_keys[pos / 2]   = held;
          pos                  = pos / 2;
        end
      end
    end else begin
      if (heap_size == 0) begin
        res.status = mhpq_pkg::STATUS_EMPTY;
      end else begin
        res.popped_value = heap_keys[1];
        heap_keys[1]     = heap_keys[heap_size];
        heap_size--;
        pos = 1;
        while (2 * pos <= heap_size) begin
          child = 2 * pos;
          if (child + 1 <= heap_size && heap_keys[child + 1] < heap_keys[child]) begin
            child = child + 1;
          end
          if (heap_keys[child] < heap_keys[pos]) begin
            held             = heap_keys[pos];
            heap_keys[pos]   = heap_keys[child];
            heap_keys[child] = held;
            pos              = child;
          end else begin
            break;
          end
        end
      end
    end
    res.occupancy = 6'(heap_size);
    return res;
  endfunction

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3, 4: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      default: return $signed(32'($urandom));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // The caller is at a falling edge; start is left high so that the next
  // item can follow without a gap.
  task automatic send_item(input logic cmd, input logic signed [31:0] key);
    mhpq_pkg::request_t req;
    req.command   = cmd;
    req.key_value = key;
    if (gaps_enabled && $urandom_range(0, 99) < 27) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    start   = 1'b1;
    request = req;
    do @(posedge clk); while (busy);
    pending_results.push_back(heap_apply(req));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    mhpq_pkg::result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result transfer with no item outstanding: %h", result));
      end else begin
        want = pending_results.pop_front();
        if (result.popped_value !== want.popped_value) begin
          report_mismatch($sformatf("popped_value %0d, expected %0d",
                                    result.popped_value, want.popped_value));
        end
        if (result.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", result.status, want.status));
        end
        if (result.occupancy !== want.occupancy) begin
          report_mismatch($sformatf("occupancy %0d, expected %0d",
                                    result.occupancy, want.occupancy));
        end
      end
    end
  end

  task automatic test_empty_heap();
    send_item(mhpq_pkg::CMD_POP, 32'sh0000_0000);
    send_item(mhpq_pkg::CMD_POP, -32'sd1);
    send_item(mhpq_pkg::CMD_INSERT, 32'sd42);
    send_item(mhpq_pkg::CMD_POP, 32'sd0);
    send_item(mhpq_pkg::CMD_POP, 32'sh5555_5555);
    wait_idle();
  endtask

  task automatic test_key_extremes();
    send_item(mhpq_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
    send_item(mhpq_pkg::CMD_INSERT, 32'sh8000_0000);
    send_item(mhpq_pkg::CMD_INSERT, 32'sd0);
    send_item(mhpq_pkg::CMD_INSERT, -32'sd1);
    send_item(mhpq_pkg::CMD_INSERT, 32'sd1);
    repeat (5) send_item(mhpq_pkg::CMD_POP, 32'sh2AAA_AAAA);
    wait_idle();
  endtask

  task automatic test_equal_keys();
    send_item(mhpq_pkg::CMD_INSERT, 32'sd5);
    send_item(mhpq_pkg::CMD_INSERT, 32'sd5);
    send_item(mhpq_pkg::CMD_INSERT, 32'sd5);
    send_item(mhpq_pkg::CMD_INSERT, 32'sd3);
    send_item(mhpq_pkg::CMD_INSERT, 32'sd3);
    send_item(mhpq_pkg::CMD_INSERT, 32'sd5);
    repeat (4) send_item(mhpq_pkg::CMD_POP, 32'sd0);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int count, input int insert_pct);
    logic cmd;
    repeat (count) begin
      cmd = ($urandom_range(0, 99) < insert_pct) ? mhpq_pkg::CMD_INSERT : mhpq_pkg::CMD_POP;
      send_item(cmd, pick_key());
    end
    wait_idle();
  endtask

  task automatic test_fill_and_overflow();
    gaps_enabled = 1'b0;
    test_random_traffic(60, 90);
    gaps_enabled = 1'b1;
  endtask

  task automatic test_drain_to_empty();
    test_random_traffic(60, 10);
  endtask

  task automatic test_mixed_traffic();
    test_random_traffic(70, 65);
    test_random_traffic(70, 35);
    test_random_traffic(60, 50);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_heap();
    test_key_extremes();
    test_equal_keys();
    test_fill_and_overflow();
    test_drain_to_empty();
    test_mixed_traffic();
    test_fill_and_overflow();
    if (error_count == 0) begin
      $display("tb_min_heap_priority_queue_unit passed");
    end else begin
      $display("tb_min_heap_priority_queue_unit failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb_min_heap_priority_queue_unit failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_ram.sv
hw/rtl/min_heap_priority_queue_unit.sv
hw/rtl/mhpq_checker.sv
dv/tb_min_heap_priority_queue_unit.sv
